@@ rtl/deq_pkg.sv @@
`default_nettype none

package deq_pkg;

   // Operation codes carried on the request tuser.
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SEARCH     = 3'd4
   } op_type;

   // Status codes carried on the response tuser.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 5;
   localparam int POSITION_W = 4;
   localparam int OP_W       = 3;
   localparam int STATUS_W   = 2;

   // Response tdata: front, back, count, found, position, padded to whole bytes.
   localparam int RSP_FIELDS_W = 2 * VALUE_W + COUNT_W + 1 + POSITION_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Value reported for front and back when nothing is stored.
   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

endpackage

`default_nettype wire

@@ rtl/deq_store.sv @@
`default_nettype none

// Ring storage: one write port and two registered read ports.
module deq_store #(
   parameter int DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire logic [deq_pkg::VALUE_W-1:0]   wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr_b,
   output logic      [deq_pkg::VALUE_W-1:0]   rd_data_a,
   output logic      [deq_pkg::VALUE_W-1:0]   rd_data_b
);

   logic [deq_pkg::VALUE_W-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Both read ports are registered and return data in the cycle after the address.
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

@@ rtl/double_ended_queue_with_search_unit.sv @@
`default_nettype none

// Bounded double-ended queue of signed 32-bit values with a linear search.
// Each request word is one operation: req_tuser holds the operation code
// (push front, push back, pop front, pop back, search) and req_tdata the
// value to push or to look for. Every request yields exactly one response
// word carrying the front and back values (-1 when empty), the count, the
// found flag with the position of the first match, and a status code.
// A push or pop passes three steps from acceptance to a loaded response:
// execute, fetch of front and back from the store, capture. The next
// request is taken once the sequencer is back in idle after the capture.
// A search walks the stored entries through one store read port and one
// comparator, one entry per cycle. A hit ends the walk at the first match,
// a miss once every stored entry has been compared.
// Only one request is in flight; req_tready is high while the sequencer is
// idle. The response register lets the next request start while a response
// still waits; if the receiver stalls, the following response holds in the
// capture step until the register frees. Reset empties the queue and drops
// any pending response; store contents are not cleared.
module double_ended_queue_with_search_unit #(
   parameter int CAPACITY = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // req_tdata: value[31:0]
   input  wire logic [deq_pkg::VALUE_W-1:0]       req_tdata,
   // req_tuser: operation[2:0]
   input  wire logic [deq_pkg::OP_W-1:0]          req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // rsp_tdata: front_value[31:0], back_value[63:32], entry_count[68:64],
   // found[69], found_position[73:70], zero padding[79:74]
   output logic      [deq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // rsp_tuser: status[1:0]
   output logic      [deq_pkg::STATUS_W-1:0]      rsp_tuser
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [IW:0]   CAP_SUM   = (IW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
   localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_EXEC    = 5'b00010,
      S_SEARCH  = 5'b00100,
      S_FETCH   = 5'b01000,
      S_CAPTURE = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [IW-1:0]                head_ff, head_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic                         pend_ff, pend_in;
   logic [IW-1:0]                cand_ff, cand_in;
   logic                         found_ff, found_in;
   logic [IW-1:0]                pos_ff, pos_in;
   deq_pkg::status_type          status_ff, status_in;
   deq_pkg::op_type              op_ff;
   logic [deq_pkg::VALUE_W-1:0]  value_ff;
   logic                         out_valid_ff, out_valid_in;
   logic [deq_pkg::RSP_DATA_W-1:0] out_data_ff;
   logic [deq_pkg::STATUS_W-1:0] out_user_ff;

   logic                         wr_en;
   logic [IW-1:0]                wr_addr;
   logic [IW-1:0]                rd_addr_a, rd_addr_b;
   logic [deq_pkg::VALUE_W-1:0]  rd_data_a, rd_data_b;
   logic                         match;
   logic                         load_out;
   logic [deq_pkg::VALUE_W-1:0]  front_val, back_val;

   // Ring position of an offset from the head; the sum stays below twice the depth.
   function automatic logic [IW-1:0] ring_slot(input logic [IW-1:0] head,
                                               input logic [CW-1:0] offset);
      logic [IW:0] sum;
      sum = {1'b0, head} + (IW + 1)'(offset);
      if (sum >= CAP_SUM) begin
         sum = sum - CAP_SUM;
      end
      return sum[IW-1:0];
   endfunction

   deq_store #(
      .DEPTH(CAPACITY)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (value_ff),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign match      = pend_ff && (rd_data_a == value_ff);
   assign load_out   = (state_ff == S_CAPTURE) && (!out_valid_ff || rsp_tready);

   // Store write: pushes land in EXEC, before the head and count move.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = head_ff;
      if (state_ff == S_EXEC && count_ff != CAP_COUNT) begin
         if (op_ff == deq_pkg::OP_PUSH_FRONT) begin
            wr_en   = 1'b1;
            wr_addr = (head_ff == '0) ? LAST_SLOT : head_ff - IW'(1);
         end else if (op_ff == deq_pkg::OP_PUSH_BACK) begin
            wr_en   = 1'b1;
            wr_addr = ring_slot(head_ff, count_ff);
         end
      end
   end

   // Port A walks the entries during a search and reads the front otherwise.
   always_comb begin
      rd_addr_a = (state_ff == S_SEARCH) ? ring_slot(head_ff, idx_ff) : head_ff;
      rd_addr_b = (count_ff == '0) ? head_ff : ring_slot(head_ff, count_ff - CW'(1));
   end

   // Sequencer and queue bookkeeping.
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pend_in   = pend_ff;
      cand_in   = cand_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      status_in = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            found_in  = 1'b0;
            pos_in    = '0;
            status_in = deq_pkg::ST_OK;
            idx_in    = '0;
            pend_in   = 1'b0;
            state_in  = S_FETCH;
            unique case (op_ff)
               deq_pkg::OP_PUSH_FRONT: begin
                  if (count_ff == CAP_COUNT) begin
                     status_in = deq_pkg::ST_FULL;
                  end else begin
                     head_in  = wr_addr;
                     count_in = count_ff + CW'(1);
                  end
               end
               deq_pkg::OP_PUSH_BACK: begin
                  if (count_ff == CAP_COUNT) begin
                     status_in = deq_pkg::ST_FULL;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end
               deq_pkg::OP_POP_FRONT: begin
                  if (count_ff == '0) begin
                     status_in = deq_pkg::ST_EMPTY;
                  end else begin
                     head_in  = ring_slot(head_ff, CW'(1));
                     count_in = count_ff - CW'(1);
                  end
               end
               deq_pkg::OP_POP_BACK: begin
                  if (count_ff == '0) begin
                     status_in = deq_pkg::ST_EMPTY;
                  end else begin
                     count_in = count_ff - CW'(1);
                  end
               end
               deq_pkg::OP_SEARCH: begin
                  state_in = S_SEARCH;
               end
               default: begin
               end
            endcase
         end
         S_SEARCH: begin
            // Issue one read a cycle and compare the word read the cycle before.
            priority if (match) begin
               found_in = 1'b1;
               pos_in   = cand_ff;
               pend_in  = 1'b0;
               state_in = S_FETCH;
            end else if (idx_ff == count_ff) begin
               pend_in  = 1'b0;
               state_in = S_FETCH;
            end else begin
               cand_in = idx_ff[IW-1:0];
               pend_in = 1'b1;
               idx_in  = idx_ff + CW'(1);
            end
         end
         S_FETCH: begin
            state_in = S_CAPTURE;
         end
         S_CAPTURE: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response word assembly from the store read data.
   always_comb begin
      front_val = (count_ff == '0) ? deq_pkg::EMPTY_VALUE : rd_data_a;
      back_val  = (count_ff == '0) ? deq_pkg::EMPTY_VALUE : rd_data_b;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      cand_ff   <= cand_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      if (req_tvalid && req_tready) begin
         op_ff    <= deq_pkg::op_type'(req_tuser);
         value_ff <= req_tdata;
      end
      if (load_out) begin
         out_data_ff <= {
            (deq_pkg::RSP_DATA_W - deq_pkg::RSP_FIELDS_W)'(0),
            deq_pkg::POSITION_W'(pos_ff),
            found_ff,
            deq_pkg::COUNT_W'(count_ff),
            back_val,
            front_val
         };
         out_user_ff <= status_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

`default_nettype wire

@@ tb/sv/deque_result_checker.sv @@
`default_nettype none

// Watches both streams of the deque unit. Every accepted request word is
// run through a local model of the queue, and the result it should produce
// is queued. Every accepted response word is compared with the oldest
// queued result.
module deque_result_checker #(
   parameter int CAPACITY = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [deq_pkg::VALUE_W-1:0]       req_tdata,
   input  wire logic [deq_pkg::OP_W-1:0]          req_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [deq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire logic [deq_pkg::STATUS_W-1:0]      rsp_tuser,
   output int                                     failures,
   output int                                     pending,
   output int                                     checked,
   output int                                     full_rejects,
   output int                                     empty_rejects,
   output int                                     search_hits
);

   localparam int REPORT_LIMIT = 10;

   // Bit positions of the fields in the response word.
   localparam int FRONT_LSB = 0;
   localparam int BACK_LSB  = deq_pkg::VALUE_W;
   localparam int COUNT_LSB = 2 * deq_pkg::VALUE_W;
   localparam int FOUND_BIT = COUNT_LSB + deq_pkg::COUNT_W;
   localparam int POS_LSB   = FOUND_BIT + 1;

   typedef struct {
      logic [deq_pkg::VALUE_W-1:0]    front;
      logic [deq_pkg::VALUE_W-1:0]    back;
      logic [deq_pkg::COUNT_W-1:0]    count;
      logic                           found;
      logic [deq_pkg::POSITION_W-1:0] position;
      logic [deq_pkg::STATUS_W-1:0]   status;
   } deque_result_type;

   // Local copy of the queue: ring store, head slot and fill level.
   logic [deq_pkg::VALUE_W-1:0] entries [CAPACITY];
   int                          head_slot;
   int                          depth;
   deque_result_type            awaited_results [$];

   initial begin
      failures      = 0;
      pending       = 0;
      checked       = 0;
      full_rejects  = 0;
      empty_rejects = 0;
      search_hits   = 0;
      head_slot     = 0;
      depth         = 0;
   end

   // Applies one operation to the local queue and returns the response it yields.
   function automatic deque_result_type apply_deque_op(
         input logic [deq_pkg::OP_W-1:0]    op,
         input logic [deq_pkg::VALUE_W-1:0] value);
      deque_result_type r;
      int               i;
      r.status   = deq_pkg::ST_OK;
      r.found    = 1'b0;
      r.position = '0;
      case (op)
         deq_pkg::OP_PUSH_FRONT: begin
            if (depth >= CAPACITY) begin
               r.status = deq_pkg::ST_FULL;
            end else begin
               head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
               entries[head_slot] = value;
               depth++;
            end
         end
         deq_pkg::OP_PUSH_BACK: begin
            if (depth >= CAPACITY) begin
               r.status = deq_pkg::ST_FULL;
            end else begin
               entries[(head_slot + depth) % CAPACITY] = value;
               depth++;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            if (depth == 0) begin
               r.status = deq_pkg::ST_EMPTY;
            end else begin
               head_slot = (head_slot + 1) % CAPACITY;
               depth--;
            end
         end
         deq_pkg::OP_POP_BACK: begin
            if (depth == 0) begin
               r.status = deq_pkg::ST_EMPTY;
            end else begin
               depth--;
            end
         end
         deq_pkg::OP_SEARCH: begin
            // The first match counted from the front wins.
            for (i = 0; i < depth; i++) begin
               if (!r.found && entries[(head_slot + i) % CAPACITY] == value) begin
                  r.found    = 1'b1;
                  r.position = deq_pkg::POSITION_W'(i);
               end
            end
         end
         default: begin
         end
      endcase
      if (depth == 0) begin
         r.front = deq_pkg::EMPTY_VALUE;
         r.back  = deq_pkg::EMPTY_VALUE;
      end else begin
         r.front = entries[head_slot];
         r.back  = entries[(head_slot + depth - 1) % CAPACITY];
      end
      r.count = deq_pkg::COUNT_W'(depth);
      return r;
   endfunction

   // Compare responses first, then predict for the request of this edge.
   always @(posedge clock) begin
      deque_result_type want;
      deque_result_type got;
      if (reset) begin
         head_slot = 0;
         depth     = 0;
         awaited_results.delete();
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.front    = rsp_tdata[FRONT_LSB +: deq_pkg::VALUE_W];
            got.back     = rsp_tdata[BACK_LSB +: deq_pkg::VALUE_W];
            got.count    = rsp_tdata[COUNT_LSB +: deq_pkg::COUNT_W];
            got.found    = rsp_tdata[FOUND_BIT];
            got.position = rsp_tdata[POS_LSB +: deq_pkg::POSITION_W];
            got.status   = rsp_tuser;
            if (awaited_results.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("Unexpected response word: front=%0d back=%0d count=%0d",
                           $signed(got.front), $signed(got.back), got.count);
            end else begin
               want = awaited_results.pop_front();
               checked++;
               if (got.front !== want.front || got.back !== want.back ||
                   got.count !== want.count || got.found !== want.found ||
                   got.position !== want.position || got.status !== want.status) begin
                  failures++;
                  if (failures <= REPORT_LIMIT) begin
                     $display("Mismatch on response %0d:", checked);
                     $display("  expected front=%0d back=%0d count=%0d found=%0d",
                              $signed(want.front), $signed(want.back), want.count,
                              want.found);
                     $display("           pos=%0d status=%0d",
                              want.position, want.status);
                     $display("  actual   front=%0d back=%0d count=%0d found=%0d",
                              $signed(got.front), $signed(got.back), got.count,
                              got.found);
                     $display("           pos=%0d status=%0d",
                              got.position, got.status);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = apply_deque_op(req_tuser, req_tdata);
            if (want.status == deq_pkg::ST_FULL)
               full_rejects++;
            if (want.status == deq_pkg::ST_EMPTY)
               empty_rejects++;
            if (want.found)
               search_hits++;
            awaited_results.push_back(want);
         end
         pending <= awaited_results.size();
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`default_nettype none

// Drives operation words into the deque unit, first a directed sequence of
// corner cases and then three phases of random traffic under different idle
// patterns, and reports the checker's verdict.
module testbench;

   localparam int CAPACITY        = 16;
   localparam int ITEMS_PER_PHASE = 350;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int DRAIN_CYCLES    = CAPACITY + 10;
   localparam int POOL_N          = 8;

   // Operation codes the unit does not define.
   localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [deq_pkg::VALUE_W-1:0]    req_tdata  = '0;
   logic [deq_pkg::OP_W-1:0]       req_tuser  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [deq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [deq_pkg::STATUS_W-1:0]   rsp_tuser;

   int failures;
   int pending;
   int checked;
   int full_rejects;
   int empty_rejects;
   int search_hits;

   int tx_idle_pct = 35;
   int rx_idle_pct = 76;
   int cycle_count = 0;
   int pushes      = 0;
   int pops        = 0;
   int searches    = 0;
   int spares      = 0;

   logic [deq_pkg::VALUE_W-1:0] value_pool [POOL_N];

   double_ended_queue_with_search_unit #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   deque_result_checker #(
      .CAPACITY(CAPACITY)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .failures     (failures),
      .pending      (pending),
      .checked      (checked),
      .full_rejects (full_rejects),
      .empty_rejects(empty_rejects),
      .search_hits  (search_hits)
   );

   // Clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Presents one operation word, after a random gap, and holds it until accepted.
   task automatic issue_op(input logic [deq_pkg::OP_W-1:0]    op,
                           input logic [deq_pkg::VALUE_W-1:0] value);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      case (op)
         deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: pushes++;
         deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:   pops++;
         deq_pkg::OP_SEARCH:                            searches++;
         default:                                       spares++;
      endcase
   endtask

   // Holds the request side quiet until every response has come back.
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Values mostly come from a small pool so that searches hit and repeat.
   function automatic logic [deq_pkg::VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 50)
         return value_pool[$urandom_range(POOL_N - 1)];
      if (r < 62) begin
         case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            default: return '1;
         endcase
      end
      return $urandom();
   endfunction

   // Picks an operation code weighted by the current traffic mode.
   function automatic logic [deq_pkg::OP_W-1:0] pick_op(input traffic_mode_type mode);
      int r;
      int push_lim;
      int pop_lim;
      r = $urandom_range(99);
      case (mode)
         MODE_FILL: begin
            push_lim = 65;
            pop_lim  = 80;
         end
         MODE_DRAIN: begin
            push_lim = 15;
            pop_lim  = 75;
         end
         default: begin
            push_lim = 40;
            pop_lim  = 70;
         end
      endcase
      if (r < push_lim)
         return $urandom_range(1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
      if (r < pop_lim)
         return $urandom_range(1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
      if (r < 96)
         return deq_pkg::OP_SEARCH;
      return OP_SPARE_FIRST +
             deq_pkg::OP_W'($urandom_range(OP_SPARE_LAST - OP_SPARE_FIRST));
   endfunction

   initial begin
      int               phase;
      int               n;
      int               run_left;
      traffic_mode_type mode;

      for (n = 0; n < POOL_N; n++)
         value_pool[n] = $urandom();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: pops and a search on an empty queue, extreme values,
      // popping both elements, one from each end, filling up, pushes on a
      // full queue, a match at the deepest position and an undefined code.
      issue_op(deq_pkg::OP_POP_FRONT, $urandom());
      issue_op(deq_pkg::OP_POP_BACK, $urandom());
      issue_op(deq_pkg::OP_SEARCH, '1);
      issue_op(deq_pkg::OP_PUSH_BACK, 32'h7fff_ffff);
      issue_op(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
      issue_op(deq_pkg::OP_POP_FRONT, '0);
      issue_op(deq_pkg::OP_POP_BACK, '0);
      for (n = 0; n < CAPACITY - 1; n++)
         issue_op((n % 2) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT,
                  deq_pkg::VALUE_W'(n % 5));
      issue_op(deq_pkg::OP_PUSH_BACK, 32'h1234_5678);
      issue_op(deq_pkg::OP_PUSH_FRONT, '1);
      issue_op(deq_pkg::OP_PUSH_BACK, 32'h8000_0000);
      issue_op(deq_pkg::OP_SEARCH, 32'h1234_5678);
      issue_op(OP_SPARE_LAST, '1);

      // Random part in three idle patterns, drained between them.
      for (phase = 0; phase < 3; phase++) begin
         wait_for_responses();
         case (phase)
            0: begin
               tx_idle_pct = 35;
               rx_idle_pct = 76;
            end
            1: begin
               tx_idle_pct = 76;
               rx_idle_pct = 35;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         run_left = 0;
         mode     = MODE_MIXED;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Swing between filling and draining so that both limits are hit.
            if (run_left == 0) begin
               mode     = traffic_mode_type'($urandom_range(2));
               run_left = $urandom_range(64, 16);
            end
            run_left--;
            if ($urandom_range(49) == 0)
               value_pool[$urandom_range(POOL_N - 1)] = $urandom();
            issue_op(pick_op(mode), pick_value());
         end
      end

      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d pushes, %0d pops, %0d searches and %0d undefined codes",
               pushes, pops, searches, spares);
      $display("under three idle patterns; checked %0d responses: %0d full rejects,",
               checked, full_rejects);
      $display("%0d empty rejects, %0d search hits.", empty_rejects, search_hits);
      if (failures == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
